@@ hw/rtl/gda_pkg.sv @@
// shared types, constants and calendar helpers for the date arithmetic block
package gda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int CNT_W   = 16;
  localparam int DOY_W   = 9;
  localparam int DIST_W  = 22;
  localparam int SER_W   = 23;
  localparam int WYEAR_W = 16;
  localparam int QUO_W   = 8;

  localparam int TOP_YEAR = 9999;
  localparam int TOP_P    = TOP_YEAR - 1;
  localparam logic [SER_W-1:0] TOP_SERIAL =
    SER_W'(365 * TOP_P + TOP_P / 4 - TOP_P / 100 + TOP_P / 400 + 365);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [SER_W-1:0] DAYS_400 = SER_W'(146097);
  localparam logic [SER_W-1:0] DAYS_100 = SER_W'(36524);
  localparam logic [SER_W-1:0] DAYS_4   = SER_W'(1461);
  localparam logic [SER_W-1:0] DAYS_1   = SER_W'(365);

  // y / 100 as (y * RECIP) >> RECIP_SH, exact for all 14-bit years
  localparam logic [12:0] RECIP    = 13'd5243;
  localparam int          RECIP_SH = 19;

  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_QUO,
    CMD_SER1,
    CMD_SER2,
    CMD_CMP,
    CMD_WALK,
    CMD_PUBLISH
  } gda_op_t;

  typedef struct packed {
    gda_op_t op;
    logic    sel;   // 0: date a, 1: date b
  } gda_cmd_t;

  typedef struct packed {
    logic walk_done;
  } gda_stat_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2: r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // days in the months before m, common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd1:  r = 9'd0;
      4'd2:  r = 9'd31;
      4'd3:  r = 9'd59;
      4'd4:  r = 9'd90;
      4'd5:  r = 9'd120;
      4'd6:  r = 9'd151;
      4'd7:  r = 9'd181;
      4'd8:  r = 9'd212;
      4'd9:  r = 9'd243;
      4'd10: r = 9'd273;
      4'd11: r = 9'd304;
      4'd12: r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/gda_if.sv @@
// valid/ready channel interfaces for the date arithmetic block
interface gda_in_if;
  logic        valid;
  logic        ready;
  logic [13:0] year_a;
  logic [3:0]  month_a;
  logic [4:0]  day_a;
  logic [13:0] year_b;
  logic [3:0]  month_b;
  logic [4:0]  day_b;
  logic [15:0] add_count;

  modport source (output valid, year_a, month_a, day_a, year_b, month_b, day_b,
                  add_count, input ready);
  modport sink (input valid, year_a, month_a, day_a, year_b, month_b, day_b,
                add_count, output ready);
endinterface

interface gda_out_if;
  logic        valid;
  logic        ready;
  logic        valid_a;
  logic        valid_b;
  logic        leap_a;
  logic [8:0]  day_of_year_a;
  logic [21:0] day_distance;
  logic        a_before_b;
  logic        a_after_b;
  logic        a_equals_b;
  logic [13:0] sum_year;
  logic [3:0]  sum_month;
  logic [4:0]  sum_day;
  logic        sum_overflow;

  modport source (output valid, valid_a, valid_b, leap_a, day_of_year_a, day_distance,
                  a_before_b, a_after_b, a_equals_b, sum_year, sum_month, sum_day,
                  sum_overflow, input ready);
  modport sink (input valid, valid_a, valid_b, leap_a, day_of_year_a, day_distance,
                a_before_b, a_after_b, a_equals_b, sum_year, sum_month, sum_day,
                sum_overflow, output ready);
endinterface

@@ hw/rtl/gda_ctrl.sv @@
// sequencing state machine for the date arithmetic block
module gda_ctrl import gda_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  gda_stat_t stat,
  output gda_cmd_t  cmd
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_QA   = 10'b0000000010,
    ST_S1A  = 10'b0000000100,
    ST_S2A  = 10'b0000001000,
    ST_QB   = 10'b0000010000,
    ST_S1B  = 10'b0000100000,
    ST_S2B  = 10'b0001000000,
    ST_CMP  = 10'b0010000000,
    ST_WALK = 10'b0100000000,
    ST_FIN  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   publish;

  assign in_ready = (state == ST_IDLE);
  assign publish  = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cmd.op     = CMD_NOP;
    cmd.sel    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = ST_QA;
        end
      end
      ST_QA: begin
        cmd.op     = CMD_QUO;
        state_next = ST_S1A;
      end
      ST_S1A: begin
        cmd.op     = CMD_SER1;
        state_next = ST_S2A;
      end
      ST_S2A: begin
        cmd.op     = CMD_SER2;
        state_next = ST_QB;
      end
      ST_QB: begin
        cmd.op     = CMD_QUO;
        cmd.sel    = 1'b1;
        state_next = ST_S1B;
      end
      ST_S1B: begin
        cmd.op     = CMD_SER1;
        cmd.sel    = 1'b1;
        state_next = ST_S2B;
      end
      ST_S2B: begin
        cmd.op     = CMD_SER2;
        cmd.sel    = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.op     = CMD_CMP;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (stat.walk_done) begin
          state_next = ST_FIN;
        end else begin
          cmd.op = CMD_WALK;
        end
      end
      ST_FIN: begin
        if (publish) begin
          cmd.op     = CMD_PUBLISH;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/gda_dp.sv @@
// datapath: date checks, serial day numbers, compare and serial-to-date walk
module gda_dp import gda_pkg::*; (
  input  logic       clk,
  input  gda_cmd_t   cmd,
  output gda_stat_t  stat,
  gda_in_if.sink     in_ch,
  gda_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    PH_400, PH_100, PH_4, PH_1, PH_MON, PH_END
  } phase_t;

  // captured item
  logic [YEAR_W-1:0]  ya, yb;
  logic [MONTH_W-1:0] ma, mb;
  logic [DAY_W-1:0]   da, db;
  logic [CNT_W-1:0]   cnt;

  // per-date work
  logic [YEAR_W-1:0]  y_s;
  logic [MONTH_W-1:0] m_s;
  logic [DAY_W-1:0]   d_s;
  logic [QUO_W-1:0]   quo;
  logic [26:0]        quo_prod;
  logic [15:0]        quo100;
  logic               z100, leap_s, valid_s;
  logic [DOY_W-1:0]   ord_s;
  logic [YEAR_W-1:0]  p_s;
  logic [SER_W-1:0]   m365_s, m365;
  logic [11:0]        corr_s, corr;
  logic [DOY_W-1:0]   ord;
  logic [SER_W-1:0]   ser_s;

  // per-item results
  logic               va, vb, leapa;
  logic [DOY_W-1:0]   doya;
  logic [SER_W-1:0]   ser_a, ser_b;
  logic [SER_W-1:0]   sum_s, diff_s;
  logic [DIST_W-1:0]  distance;
  logic               bef, aft, eq, ovf;

  // walk
  phase_t             ph;
  logic [SER_W-1:0]   n, sub_s;
  logic [WYEAR_W-1:0] wy;
  logic [1:0]         k100, k1;
  logic [4:0]         k4;
  logic [MONTH_W-1:0] mo;
  logic               leap_w, take;

  assign stat.walk_done = (ph == PH_END);

  assign y_s = cmd.sel ? yb : ya;
  assign m_s = cmd.sel ? mb : ma;
  assign d_s = cmd.sel ? db : da;

  assign quo_prod = 27'(y_s) * 27'(RECIP);

  // leap rule from y/100: divisible by 100 when y equals 100*quo
  assign quo100  = (16'(quo) << 6) + (16'(quo) << 5) + (16'(quo) << 2);
  assign z100    = (16'(y_s) == quo100);
  assign leap_s  = (y_s[1:0] == 2'b00) && (!z100 || (quo[1:0] == 2'b00));
  assign valid_s = (y_s != '0) && (m_s >= 4'd1) && (m_s <= MON_DEC) && (d_s != '0) &&
                   (d_s <= month_days(m_s, leap_s));
  assign ord_s   = days_before(m_s) + DOY_W'(d_s) +
                   DOY_W'(leap_s && (m_s > MON_FEB));
  assign p_s     = y_s - YEAR_W'(1);
  assign m365_s  = SER_W'(p_s) * SER_W'(365);
  // p/4 - p/100 + p/400 with p = y-1
  assign corr_s  = 12'(p_s >> 2) - (12'(quo) - 12'(z100)) +
                   (12'(quo >> 2) - 12'(z100 && (quo[1:0] == 2'b00)));
  assign ser_s   = m365 + SER_W'(corr) + SER_W'(ord);

  assign sum_s  = ser_a + SER_W'(cnt);
  assign diff_s = (ser_a > ser_b) ? (ser_a - ser_b) : (ser_b - ser_a);

  // walked year is leap when it is the fourth of its 4-year group, except
  // the last group of a century that is not the fourth century
  assign leap_w = (k1 == 2'd3) && ((k4 != 5'd24) || (k100 == 2'd3));

  always_comb begin
    sub_s = '0;
    take  = 1'b0;
    case (ph)
      PH_400: begin
        sub_s = DAYS_400;
        take  = (n >= DAYS_400);
      end
      PH_100: begin
        sub_s = DAYS_100;
        take  = (k100 != 2'd3) && (n >= DAYS_100);
      end
      PH_4: begin
        sub_s = DAYS_4;
        take  = (n >= DAYS_4);
      end
      PH_1: begin
        sub_s = DAYS_1;
        take  = (k1 != 2'd3) && (n >= DAYS_1);
      end
      PH_MON: begin
        sub_s = SER_W'(month_days(mo, leap_w));
        take  = (mo != MON_DEC) && (n >= sub_s);
      end
      default: begin
        sub_s = '0;
        take  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        ya  <= in_ch.year_a;
        ma  <= in_ch.month_a;
        da  <= in_ch.day_a;
        yb  <= in_ch.year_b;
        mb  <= in_ch.month_b;
        db  <= in_ch.day_b;
        cnt <= in_ch.add_count;
      end
      CMD_QUO: begin
        quo <= quo_prod[RECIP_SH +: QUO_W];
      end
      CMD_SER1: begin
        m365 <= m365_s;
        corr <= corr_s;
        ord  <= ord_s;
        if (cmd.sel) begin
          vb <= valid_s;
        end else begin
          va    <= valid_s;
          leapa <= leap_s;
          doya  <= ord_s;
        end
      end
      CMD_SER2: begin
        if (cmd.sel) begin
          ser_b <= ser_s;
        end else begin
          ser_a <= ser_s;
        end
      end
      CMD_CMP: begin
        distance <= (va && vb) ? ((diff_s > SER_W'(DIST_MAX)) ? DIST_MAX
                                                              : diff_s[DIST_W-1:0])
                               : '0;
        bef  <= va && vb && (ser_a < ser_b);
        aft  <= va && vb && (ser_a > ser_b);
        eq   <= va && vb && (ser_a == ser_b);
        ovf  <= va && (sum_s > TOP_SERIAL);
        n    <= sum_s - SER_W'(1);
        wy   <= WYEAR_W'(1);
        ph   <= PH_400;
        k100 <= '0;
        k4   <= '0;
        k1   <= '0;
        mo   <= 4'd1;
      end
      CMD_WALK: begin
        if (take) begin
          n <= n - sub_s;
          case (ph)
            PH_400: wy <= wy + WYEAR_W'(400);
            PH_100: begin
              wy   <= wy + WYEAR_W'(100);
              k100 <= k100 + 2'd1;
            end
            PH_4: begin
              wy <= wy + WYEAR_W'(4);
              k4 <= k4 + 5'd1;
            end
            PH_1: begin
              wy <= wy + WYEAR_W'(1);
              k1 <= k1 + 2'd1;
            end
            PH_MON: mo <= mo + 4'd1;
            default: wy <= wy;
          endcase
        end else begin
          case (ph)
            PH_400:  ph <= PH_100;
            PH_100:  ph <= PH_4;
            PH_4:    ph <= PH_1;
            PH_1:    ph <= PH_MON;
            default: ph <= PH_END;
          endcase
        end
      end
      CMD_PUBLISH: begin
        out_ch.valid_a       <= va;
        out_ch.valid_b       <= vb;
        out_ch.leap_a        <= leapa;
        out_ch.day_of_year_a <= va ? doya : '0;
        out_ch.day_distance  <= distance;
        out_ch.a_before_b    <= bef;
        out_ch.a_after_b     <= aft;
        out_ch.a_equals_b    <= eq;
        out_ch.sum_overflow  <= ovf;
        if (!va) begin
          out_ch.sum_year  <= '0;
          out_ch.sum_month <= '0;
          out_ch.sum_day   <= '0;
        end else if (ovf) begin
          out_ch.sum_year  <= YEAR_W'(TOP_YEAR);
          out_ch.sum_month <= MON_DEC;
          out_ch.sum_day   <= 5'd31;
        end else begin
          out_ch.sum_year  <= wy[YEAR_W-1:0];
          out_ch.sum_month <= mo;
          out_ch.sum_day   <= n[DAY_W-1:0] + 5'd1;
        end
      end
      default: begin
        quo <= quo;
      end
    endcase
  end

endmodule

@@ hw/rtl/gregorian_date_arithmetic.sv @@
// top level of the proleptic gregorian date arithmetic block
//
//   channel  dir  handshake      contents
//   in_ch    in   valid/ready    two dates (year, month, day) and a day count
//   out_ch   out  valid/ready    validity, leap, day of year, distance, order, sum date
//
// one item at a time; fixed steps (accept, two date passes of quotient and
//   first and second serial step, compare, publish) and the walk, which
//   peels 400/100/4/1-year chunks and months off the sum, one subtract and
//   compare per cycle
// rst is synchronous and clears the sequencer and the output valid flag
// a finished item waits in the output register; the next item is taken and
//   worked on meanwhile, and its result waits until the register drains
module gregorian_date_arithmetic import gda_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  gda_in_if.sink   in_ch,
  gda_out_if.source out_ch
);

  gda_cmd_t  cmd;
  gda_stat_t stat;
  logic      in_ready;
  logic      out_valid;

  // sequencer: steps per-date checks, compare, and the walk
  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath holds the item, intermediate day numbers and the output register
  gda_dp u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

@@ hw/rtl/gda_chk.sv @@
// port-level assertions for the date arithmetic block, bound to the top level
module gda_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        valid_a,
  input logic        valid_b,
  input logic [8:0]  day_of_year_a,
  input logic [21:0] day_distance,
  input logic        a_before_b,
  input logic        a_after_b,
  input logic        a_equals_b,
  input logic        sum_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_invalid_a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_a |-> day_of_year_a == 9'd0 && day_distance == 22'd0 &&
                              !sum_overflow && !a_equals_b)
    else $error("invalid first date left dependent results set");

  a_invalid_b_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_b |-> !a_before_b && !a_after_b && !a_equals_b)
    else $error("order flags set with invalid second date");

  a_order_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_a && valid_b |->
      $onehot({a_before_b, a_after_b, a_equals_b}) &&
      (a_equals_b == (day_distance == 22'd0)))
    else $error("order flags disagree with distance");

endmodule

bind gregorian_date_arithmetic gda_chk u_gda_chk (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .valid_a       (out_ch.valid_a),
  .valid_b       (out_ch.valid_b),
  .day_of_year_a (out_ch.day_of_year_a),
  .day_distance  (out_ch.day_distance),
  .a_before_b    (out_ch.a_before_b),
  .a_after_b     (out_ch.a_after_b),
  .a_equals_b    (out_ch.a_equals_b),
  .sum_overflow  (out_ch.sum_overflow)
);
